// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the deque block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is asserted.
`define ASSERT_ON_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque checker: property violated");

// Concurrent assertion on a clock that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deque checker: property violated");

`endif

// File: rtl/rdcd_pkg.sv
// ----------------------------------------------------------------------------
// rdcd_pkg
// Types, codes and sizes shared by the reversible circular deque modules.
// ----------------------------------------------------------------------------
package rdcd_pkg;

    // Default sizing of the element store.
    localparam int DEPTH_DEFAULT         = 256;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;

    // Command queue between the front end and the execution unit.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Field widths on the stream ports.
    localparam int ACTION_W     = 4;
    localparam int POSITION_W   = 8;
    localparam int VALUE_W      = 32;
    localparam int READ_VALUE_W = 32;
    localparam int FOUND_W      = 8;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 9;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 56;

    // Operation codes carried in the input tuser field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 4'd0,
        ACT_PUSH_FRONT = 4'd1,
        ACT_POP_BACK   = 4'd2,
        ACT_POP_FRONT  = 4'd3,
        ACT_READ       = 4'd4,
        ACT_WRITE      = 4'd5,
        ACT_REVERSE    = 4'd6,
        ACT_CLEAR      = 4'd7,
        ACT_FIND       = 4'd8,
        ACT_BSEARCH    = 4'd9,
        ACT_NOP        = 4'd15
    } action_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_EMPTY     = 3'd2,
        STATUS_RANGE     = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    // Decoded command as it sits in the command queue.
    typedef struct packed {
        action_t                 action;
        logic [POSITION_W-1:0]   position;
        logic [VALUE_W-1:0]      value;
    } op_t;

    // Execution unit sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACCESS,
        BK_FIND,
        BK_BS_ADDR,
        BK_BS_CMP
    } back_state_t;

endpackage

// File: rtl/reversible_circular_deque_unit.sv
// ----------------------------------------------------------------------------
// reversible_circular_deque_unit
// Fixed-capacity circular deque with a reversible logical order, driven by
// one command beat per operation and answering with one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel: the action code in tuser, the
//   position and value in tdata. Each command returns exactly one beat on
//   the m_axis channel, in command order.
//   Push, write, reverse, clear, no-op and any rejected command load the
//   result register as they leave the command queue; pop and read wait
//   for the registered store read; find compares one stored slot per
//   cycle; bsearch takes each probe through an address state and then a
//   compare state. Throughput: one command per cycle for push, write,
//   reverse, clear, no-op and rejected commands while the result beat is
//   taken; the execution unit runs one command at a time, with the single
//   store port setting the pace of pops, reads and searches.
//   A two-entry command queue sits in front of the execution unit, so the
//   input keeps taking beats while a result waits or a search runs.
//   Reset (aresetn low, synchronous) empties the deque, clears the reversed
//   flag and the queue and drops any pending result. Store contents are not
//   cleared; a never-written slot is never read by legal use.
//   When m_axis_tready is low the result beat holds, the execution unit
//   waits, and s_axis_tready falls once the command queue fills.
// ----------------------------------------------------------------------------
module reversible_circular_deque_unit #(
    parameter int DEPTH         = rdcd_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_WIDTH = rdcd_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: position [7:0], value [39:8]
    input  logic [rdcd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action [3:0]
    input  logic [rdcd_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: read_value [31:0], found_position [39:32], status [42:40],
    //        count [51:43], reversed [52], zero [55:53]
    output logic [rdcd_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    rdcd_pkg::op_t  front_op;
    rdcd_pkg::op_t  head_op;

    // Command decode and input handshake.
    rdcd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (front_op)
    );

    // Command queue between the two sides.
    rdcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    // Execution unit with the element store and result register.
    rdcd_back #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_op          (head_op),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: rtl/rdcd_queue.sv
// ----------------------------------------------------------------------------
// rdcd_queue
// Small command queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module rdcd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rdcd_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rdcd_pkg::op_t  head_op
);

    rdcd_pkg::op_t                       entry_reg [rdcd_pkg::QUEUE_DEPTH];
    logic [rdcd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rdcd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rdcd_pkg::QUEUE_CNT_W-1:0]    cnt_reg, cnt_next;

    localparam logic [rdcd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        rdcd_pkg::QUEUE_PTR_W'(rdcd_pkg::QUEUE_DEPTH - 1);
    localparam logic [rdcd_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        rdcd_pkg::QUEUE_CNT_W'(rdcd_pkg::QUEUE_DEPTH);

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: rtl/rdcd_front.sv
// ----------------------------------------------------------------------------
// rdcd_front
// Input side: takes command beats, classifies the action code and hands the
// decoded command to the command queue.
// ----------------------------------------------------------------------------
module rdcd_front (
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: position [7:0], value [39:8]
    input  logic [rdcd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action [3:0]
    input  logic [rdcd_pkg::ACTION_W-1:0]       s_axis_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output rdcd_pkg::op_t                       q_op
);

    // A beat is taken whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Split the payload and fold unused action codes into a no-op.
    always_comb begin
        q_op.position = s_axis_tdata[rdcd_pkg::POSITION_W-1:0];
        q_op.value    = s_axis_tdata[rdcd_pkg::POSITION_W +: rdcd_pkg::VALUE_W];
        unique case (s_axis_tuser) inside
            rdcd_pkg::ACT_PUSH_BACK, rdcd_pkg::ACT_PUSH_FRONT,
            rdcd_pkg::ACT_POP_BACK,  rdcd_pkg::ACT_POP_FRONT,
            rdcd_pkg::ACT_READ,      rdcd_pkg::ACT_WRITE,
            rdcd_pkg::ACT_REVERSE,   rdcd_pkg::ACT_CLEAR,
            rdcd_pkg::ACT_FIND,      rdcd_pkg::ACT_BSEARCH: begin
                q_op.action = rdcd_pkg::action_t'(s_axis_tuser);
            end
            default: begin
                q_op.action = rdcd_pkg::ACT_NOP;
            end
        endcase
    end

endmodule

// File: rtl/rdcd_back.sv
// ----------------------------------------------------------------------------
// rdcd_back
// Execution unit: holds the element store and the deque pointers, carries
// out one command at a time and drives the result register.
// ----------------------------------------------------------------------------
module rdcd_back #(
    parameter int DEPTH         = rdcd_pkg::DEPTH_DEFAULT,
    parameter int ELEMENT_WIDTH = rdcd_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  rdcd_pkg::op_t                       q_op,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: read_value [31:0], found_position [39:32], status [42:40],
    //        count [51:43], reversed [52], zero [55:53]
    output logic [rdcd_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > rdcd_pkg::COUNT_W) ? CW : rdcd_pkg::COUNT_W;
    localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE      = CW'(1);

    // Store and pointer state.
    logic [ELEMENT_WIDTH-1:0]   store_mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0]   rd_data_reg;
    logic [PW-1:0]              head_reg, head_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic                       rev_reg, rev_next;

    // Sequencer state.
    rdcd_pkg::back_state_t      state_reg, state_next;
    rdcd_pkg::op_t              op_reg, op_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              mid_reg, mid_next;

    // Result register.
    logic                               m_valid_reg, m_valid_next;
    logic [rdcd_pkg::READ_VALUE_W-1:0]  rv_reg, rv_next;
    logic [rdcd_pkg::FOUND_W-1:0]       found_reg, found_next;
    rdcd_pkg::status_t                  status_reg, status_next;
    logic [rdcd_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic                               reversed_reg, reversed_next;

    // Datapath signals.
    logic [CW-1:0]              addr_idx;
    logic                       addr_logical;
    logic [CW-1:0]              addr_off;
    logic [PW:0]                addr_sum;
    logic [PW-1:0]              slot;
    logic [PW-1:0]              head_inc;
    logic                       mem_we;
    logic                       rd_en;
    logic                       out_free;
    logic                       load_out;
    logic                       is_full;
    logic                       is_empty;
    logic                       in_range;
    logic [ELEMENT_WIDTH-1:0]   in_elem;
    logic [ELEMENT_WIDTH-1:0]   key_elem;
    logic [rdcd_pkg::READ_VALUE_W-1:0] res_rv;
    logic [CW-1:0]              res_found;
    rdcd_pkg::status_t          res_status;
    logic [WW-1:0]              found_wide;
    logic [WW-1:0]              count_wide;

    // Logical index to physical slot, with a single wrap correction.
    always_comb begin
        addr_off = (addr_logical && rev_reg) ? (fill_reg - ONE - addr_idx) : addr_idx;
        addr_sum = {1'b0, head_reg} + (PW + 1)'(addr_off);
        slot     = (addr_sum >= DEPTH_X) ? PW'(addr_sum - DEPTH_X) : addr_sum[PW-1:0];
    end

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign in_range = (WW'(q_op.position) < WW'(fill_reg));
    assign in_elem  = ELEMENT_WIDTH'(q_op.value);
    assign key_elem = ELEMENT_WIDTH'(op_reg.value);
    assign out_free = !m_valid_reg || m_axis_tready;

    // Sequencer: next state, store access and result.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        rev_next     = rev_reg;
        k_next       = k_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        addr_idx     = '0;
        addr_logical = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        q_pop        = 1'b0;
        load_out     = 1'b0;
        res_rv       = '0;
        res_found    = '0;
        res_status   = rdcd_pkg::STATUS_OK;

        unique case (state_reg)
            rdcd_pkg::BK_IDLE: begin
                // A command starts only when the result register is free.
                if (q_valid && out_free) begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    unique case (q_op.action) inside
                        rdcd_pkg::ACT_PUSH_BACK, rdcd_pkg::ACT_PUSH_FRONT: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                res_status = rdcd_pkg::STATUS_FULL;
                            end else if ((q_op.action == rdcd_pkg::ACT_PUSH_BACK) != rev_reg) begin
                                addr_idx  = fill_reg;
                                mem_we    = 1'b1;
                                fill_next = fill_reg + ONE;
                            end else begin
                                // One slot below the head, wrapped.
                                addr_idx  = CW'(DEPTH - 1);
                                mem_we    = 1'b1;
                                head_next = slot;
                                fill_next = fill_reg + ONE;
                            end
                        end
                        rdcd_pkg::ACT_POP_BACK, rdcd_pkg::ACT_POP_FRONT: begin
                            if (is_empty) begin
                                load_out   = 1'b1;
                                res_status = rdcd_pkg::STATUS_EMPTY;
                            end else begin
                                addr_idx     = (q_op.action == rdcd_pkg::ACT_POP_BACK) ?
                                               (fill_reg - ONE) : '0;
                                addr_logical = 1'b1;
                                rd_en        = 1'b1;
                                state_next   = rdcd_pkg::BK_ACCESS;
                            end
                        end
                        rdcd_pkg::ACT_READ, rdcd_pkg::ACT_WRITE: begin
                            addr_idx     = CW'(q_op.position);
                            addr_logical = 1'b1;
                            if (!in_range) begin
                                load_out   = 1'b1;
                                res_status = rdcd_pkg::STATUS_RANGE;
                            end else if (q_op.action == rdcd_pkg::ACT_READ) begin
                                rd_en      = 1'b1;
                                state_next = rdcd_pkg::BK_ACCESS;
                            end else begin
                                load_out = 1'b1;
                                mem_we   = 1'b1;
                            end
                        end
                        rdcd_pkg::ACT_REVERSE: begin
                            load_out = 1'b1;
                            rev_next = !rev_reg;
                        end
                        rdcd_pkg::ACT_CLEAR: begin
                            load_out  = 1'b1;
                            head_next = '0;
                            fill_next = '0;
                        end
                        rdcd_pkg::ACT_FIND: begin
                            if (is_empty) begin
                                load_out   = 1'b1;
                                res_status = rdcd_pkg::STATUS_NOT_FOUND;
                            end else begin
                                addr_idx   = '0;
                                rd_en      = 1'b1;
                                k_next     = '0;
                                state_next = rdcd_pkg::BK_FIND;
                            end
                        end
                        rdcd_pkg::ACT_BSEARCH: begin
                            lo_next    = '0;
                            hi_next    = fill_reg;
                            state_next = rdcd_pkg::BK_BS_ADDR;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            // Read data for a pop or an indexed read is here. The result
            // register was freed when the command started, so it is free now.
            rdcd_pkg::BK_ACCESS: begin
                load_out   = 1'b1;
                res_rv     = rdcd_pkg::READ_VALUE_W'($signed(rd_data_reg));
                state_next = rdcd_pkg::BK_IDLE;
                if (op_reg.action == rdcd_pkg::ACT_POP_BACK ||
                    op_reg.action == rdcd_pkg::ACT_POP_FRONT) begin
                    fill_next = fill_reg - ONE;
                    if ((op_reg.action == rdcd_pkg::ACT_POP_BACK) == rev_reg) begin
                        head_next = head_inc;
                    end
                end
            end

            // Linear scan in physical order; one slot compared per cycle
            // while the next one is being read.
            rdcd_pkg::BK_FIND: begin
                if (rd_data_reg == key_elem) begin
                    load_out   = 1'b1;
                    res_found  = rev_reg ? (fill_reg - ONE - k_reg) : k_reg;
                    state_next = rdcd_pkg::BK_IDLE;
                end else if (k_reg == fill_reg - ONE) begin
                    load_out   = 1'b1;
                    res_status = rdcd_pkg::STATUS_NOT_FOUND;
                    state_next = rdcd_pkg::BK_IDLE;
                end else begin
                    k_next   = k_reg + ONE;
                    addr_idx = k_reg + ONE;
                    rd_en    = 1'b1;
                end
            end

            // Binary search: pick the midpoint and read it.
            rdcd_pkg::BK_BS_ADDR: begin
                if (lo_reg >= hi_reg) begin
                    load_out   = 1'b1;
                    res_status = rdcd_pkg::STATUS_NOT_FOUND;
                    state_next = rdcd_pkg::BK_IDLE;
                end else begin
                    mid_next     = lo_reg + ((hi_reg - ONE - lo_reg) >> 1);
                    addr_idx     = mid_next;
                    addr_logical = 1'b1;
                    rd_en        = 1'b1;
                    state_next   = rdcd_pkg::BK_BS_CMP;
                end
            end

            // Binary search: compare the midpoint and narrow the bounds.
            rdcd_pkg::BK_BS_CMP: begin
                if (rd_data_reg == key_elem) begin
                    load_out   = 1'b1;
                    res_found  = mid_reg;
                    state_next = rdcd_pkg::BK_IDLE;
                end else if ($signed(rd_data_reg) < $signed(key_elem)) begin
                    lo_next    = mid_reg + ONE;
                    state_next = rdcd_pkg::BK_BS_ADDR;
                end else begin
                    hi_next    = mid_reg;
                    state_next = rdcd_pkg::BK_BS_ADDR;
                end
            end

            default: begin
                state_next = rdcd_pkg::BK_IDLE;
            end
        endcase
    end

    // Result register contents, masked to the field widths.
    always_comb begin
        found_wide    = WW'(res_found);
        count_wide    = WW'(fill_next);
        m_valid_next  = m_valid_reg;
        rv_next       = rv_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        reversed_next = reversed_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            rv_next       = res_rv;
            found_next    = found_wide[rdcd_pkg::FOUND_W-1:0];
            status_next   = res_status;
            count_next    = count_wide[rdcd_pkg::COUNT_W-1:0];
            reversed_next = rev_next;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rdcd_pkg::BK_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        k_reg        <= k_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        rv_reg       <= rv_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        reversed_reg <= reversed_next;
    end

    // Element store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[slot] <= in_elem;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[slot];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, reversed_reg, count_reg, status_reg, found_reg, rv_reg};

endmodule

// File: rtl/rdcd_checker.sv
// ----------------------------------------------------------------------------
// rdcd_checker
// Port-level checks on the result channel of the deque, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdcd_checker #(
    parameter int DEPTH = rdcd_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rdcd_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    logic [rdcd_pkg::READ_VALUE_W-1:0]  f_read_value;
    logic [rdcd_pkg::FOUND_W-1:0]       f_found;
    logic [rdcd_pkg::STATUS_W-1:0]      f_status;
    logic [rdcd_pkg::COUNT_W-1:0]       f_count;
    logic                               stall_beat;
    logic                               fail_beat;
    logic                               full_beat;

    assign f_read_value = m_axis_tdata[31:0];
    assign f_found      = m_axis_tdata[39:32];
    assign f_status     = m_axis_tdata[42:40];
    assign f_count      = m_axis_tdata[51:43];

    // Qualified views of the result beat.
    assign stall_beat = m_axis_tvalid && !m_axis_tready;
    assign fail_beat  = m_axis_tvalid && (f_status != rdcd_pkg::STATUS_OK);
    assign full_beat  = m_axis_tvalid && (f_status == rdcd_pkg::STATUS_FULL);

    // A stalled result beat holds its contents.
    `ASSERT_ON_CLK(a_stall_hold, aclk, aresetn, stall_beat |=> m_axis_tvalid && $stable(m_axis_tdata))

    // No pending result survives reset.
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_axis_tvalid)

    // The element count never exceeds the capacity.
    `ASSERT_ON_CLK(a_count_cap, aclk, aresetn, m_axis_tvalid |-> f_count <= rdcd_pkg::COUNT_W'(DEPTH))

    // A rejected or failed command returns no data and no index.
    `ASSERT_ON_CLK(a_fail_zero, aclk, aresetn, fail_beat |-> f_read_value == '0 && f_found == '0)

    // A push refused as full reports a full deque.
    `ASSERT_ON_CLK(a_full_count, aclk, aresetn, full_beat |-> f_count == rdcd_pkg::COUNT_W'(DEPTH))

endmodule

bind reversible_circular_deque_unit rdcd_checker #(.DEPTH(DEPTH)) u_checker (.*);
